/* rtl/f64sc_pkg.sv */
// ----------------------------------------------------------------------------
// f64sc_pkg
// Types and constants shared by the checksum front end, the op queue and the
// accumulator, and the ones' complement adder used by the accumulator.
// ----------------------------------------------------------------------------
package f64sc_pkg;

	localparam int unsigned WORD_W = 32;

	// modulus 2^32-1; also the reset value of both sums and the zero code
	localparam logic [WORD_W-1:0] SUM_MOD = 32'hFFFF_FFFF;

	// one queued op: a packed word to add and/or an end of message
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              has_word;
		logic              last;
	} op_t;

	// addition modulo 2^32-1 with end-around carry; result lies in 0..2^32-1,
	// where 2^32-1 stands for zero
	function automatic logic [WORD_W-1:0] ones_add(
		input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b
	);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
	endfunction

endpackage

/* rtl/f64sc_front.sv */
// ----------------------------------------------------------------------------
// f64sc_front
// Accepts byte items, packs them little-endian into 32-bit words and emits
// one op per completed word or end of message.
// ----------------------------------------------------------------------------
module f64sc_front
	import f64sc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       byte_present,
	input  logic       end_of_message,
	output logic       push,
	output op_t        push_op
);

	logic [23:0] partial_q;
	logic [1:0]  held_q;

	logic        accept;
	logic        take_word;
	logic [23:0] pw_ins;
	logic [23:0] pw_next;
	logic [1:0]  held_next;

	assign accept    = in_valid && in_ready;
	assign take_word = byte_present && (held_q == 2'd3);

	// byte inserted at the next free lane
	always_comb begin
		case (held_q)
			2'd0:    pw_ins = {16'h0000, data_byte};
			2'd1:    pw_ins = {8'h00, data_byte, partial_q[7:0]};
			2'd2:    pw_ins = {data_byte, partial_q[15:0]};
			default: pw_ins = partial_q;
		endcase
	end

	assign pw_next   = byte_present ? pw_ins : partial_q;
	assign held_next = take_word ? 2'd0 : (byte_present ? held_q + 2'd1 : held_q);

	// op: full word, or zero-padded partial word at end of message
	always_comb begin
		push_op.word     = take_word ? {data_byte, partial_q} : {8'h00, pw_next};
		push_op.has_word = take_word || (end_of_message && (held_next != 2'd0));
		push_op.last     = end_of_message;
	end

	assign push = accept && (take_word || end_of_message);

	// byte packing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			held_q    <= '0;
		end else if (accept) begin
			if (take_word || end_of_message) begin
				partial_q <= '0;
				held_q    <= '0;
			end else begin
				partial_q <= pw_next;
				held_q    <= held_next;
			end
		end
	end

endmodule

/* rtl/f64sc_queue.sv */
// ----------------------------------------------------------------------------
// f64sc_queue
// Short first-in first-out queue of ops between front end and accumulator.
// ----------------------------------------------------------------------------
module f64sc_queue
	import f64sc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output op_t  head_op,
	output logic full,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           slots [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign head_op = slots[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/f64sc_back.sv */
// ----------------------------------------------------------------------------
// f64sc_back
// Two-stage accumulator: stage 1 adds the word into the first sum, stage 2
// adds the first sum into the second sum and loads the result register.
// ----------------------------------------------------------------------------
module f64sc_back
	import f64sc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  op_t         head_op,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_data
);

	logic [WORD_W-1:0] s1_q;
	logic [WORD_W-1:0] s2_q;

	logic              valid_s1;
	logic [WORD_W-1:0] sum1_s1;
	logic              has_word_s1;
	logic              last_s1;

	logic              out_valid_q;
	logic [63:0]       out_data_q;

	logic              advance;
	logic [WORD_W-1:0] s1_next;
	logic [WORD_W-1:0] s2_next;
	logic [WORD_W-1:0] lo_map;
	logic [WORD_W-1:0] hi_map;

	// whole back end holds while a result waits
	assign advance = !out_valid_q || out_ready;
	assign pop     = advance && !empty;

	assign s1_next = head_op.has_word ? ones_add(s1_q, head_op.word) : s1_q;
	assign s2_next = has_word_s1 ? ones_add(s2_q, sum1_s1) : s2_q;

	// zero maps to the modulus
	assign lo_map = (sum1_s1 == '0) ? SUM_MOD : sum1_s1;
	assign hi_map = (s2_next == '0) ? SUM_MOD : s2_next;

	// stage 1: first sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q        <= SUM_MOD;
			valid_s1    <= 1'b0;
			has_word_s1 <= 1'b0;
			last_s1     <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pop;
			if (pop) begin
				has_word_s1 <= head_op.has_word;
				last_s1     <= head_op.last;
				s1_q        <= head_op.last ? SUM_MOD : s1_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sum1_s1 <= s1_next;
		end
	end

	// stage 2: second sum and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_q        <= SUM_MOD;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && last_s1;
			if (valid_s1) begin
				s2_q <= last_s1 ? SUM_MOD : s2_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && last_s1) begin
			out_data_q <= {hi_map, lo_map};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* rtl/fletcher64_stream_checksum.sv */
// ----------------------------------------------------------------------------
// fletcher64_stream_checksum
// Fletcher-64 check over a byte stream: sums modulo 2^32-1 of little-endian
// 32-bit words, emitted as second_sum:first_sum at the end of each message.
//
//   channel | dir | tdata                      | tuser        | tlast
//   s_*     | in  | [7:0] data_byte            | byte_present | end_of_message
//   m_*     | out | [31:0] check_low,          | -            | -
//           |     | [63:32] check_high         |              |
//
// One item per cycle on the input. The last item of a message is written into
// the op queue, then taken into the first sum stage and then into the second
// sum stage and the result register. The adder chain per stage is one
// 32-bit end-around-carry add. Reset is immediate, no clearing pass. A stalled
// result holds the accumulator; input stalls only once the op queue of
// QDEPTH entries is full.
// ----------------------------------------------------------------------------
module fletcher64_stream_checksum
	import f64sc_pkg::*;
#(
	parameter int QDEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [31:0] check_low, [63:32] check_high
);

	logic q_push;
	op_t  q_push_op;
	logic q_pop;
	op_t  q_head_op;
	logic q_full;
	logic q_empty;

	assign s_tready = !q_full;

	// byte packing
	f64sc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.data_byte      (s_tdata),
		.byte_present   (s_tuser),
		.end_of_message (s_tlast),
		.push           (q_push),
		.push_op        (q_push_op)
	);

	// op queue
	f64sc_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_push_op),
		.pop     (q_pop),
		.head_op (q_head_op),
		.full    (q_full),
		.empty   (q_empty)
	);

	// sum accumulation
	f64sc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_op   (q_head_op),
		.empty     (q_empty),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	// neither half of a check is ever zero
	a_check_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:0] != 32'h0) && (m_tdata[63:32] != 32'h0))
		else $error("zero half in checksum result");

	// queue only fills through a push
	a_full_by_push: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(q_push))
		else $error("queue became full without a push");

	// a waiting result freezes the accumulator
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !q_pop)
		else $error("queue popped while result stalled");

endmodule
